/* design/interrupt_handler_list_table_top_defines.svh */
// ----------------------------------------------------------------------------
// Interrupt handler list table assertion macros
// Concurrent check helpers that the top level uses, clocked on clk and held
// off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_HANDLER_LIST_TABLE_TOP_DEFINES_SVH
`define INTERRUPT_HANDLER_LIST_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHLT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ihlt_pkg.sv */
// ----------------------------------------------------------------------------
// Interrupt handler list table package
// Shared widths, codes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihlt_pkg;

	localparam int MAX_SLOTS_DEF   = 8;
	localparam int NUM_VECTORS_DEF = 256;

	localparam int VEC_W      = 8;
	localparam int ID_W       = 32;
	localparam int STATUS_W   = 3;
	localparam int CLASS_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		OP_REG   = 2'd0,
		OP_UNREG = 2'd1,
		OP_DISP  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NULL      = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

	localparam logic [CLASS_W-1:0] CLS_EXC = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_HW  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_SW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HW_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SW_BASE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] HW_BASE_RST = 8'd32;
	localparam logic [CFG_DATA_W-1:0] SW_BASE_RST = 8'd48;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LEN   = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_DISP  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

endpackage

/* design/interrupt_handler_list_table_top.sv */
// ----------------------------------------------------------------------------
// Interrupt handler list table: register/unregister scan the vector's list slot by slot.
// Dispatch reads the length, then one result per cycle unless stalled; one item at a time.
// The slot scan runs one handler memory read per cycle, which sets the rate.
// Reset clears list lengths at once through per-vector valid flops; no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "interrupt_handler_list_table_top_defines.svh"

module interrupt_handler_list_table_top #(
	parameter int MAX_SLOTS   = ihlt_pkg::MAX_SLOTS_DEF,
	parameter int NUM_VECTORS = ihlt_pkg::NUM_VECTORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [ihlt_pkg::VEC_W-1:0]      vector,
	input  logic [ihlt_pkg::ID_W-1:0]       handler_id,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ihlt_pkg::STATUS_W-1:0]   status,
	output logic [ihlt_pkg::CLASS_W-1:0]    vector_class,
	output logic                            handler_valid,
	output logic [ihlt_pkg::ID_W-1:0]       handler_out,
	output logic                            eoi_valid,
	output logic [ihlt_pkg::VEC_W-1:0]      eoi_line,
	output logic                            last,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ihlt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ihlt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int LEN_W  = $clog2(MAX_SLOTS + 1);
	localparam int CNT_W  = LEN_W + 1;
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int VIDX_W = $clog2(NUM_VECTORS);
	localparam int DEPTH  = NUM_VECTORS * MAX_SLOTS;
	localparam int ADDR_W = $clog2(DEPTH);

	ihlt_pkg::state_t  state_q, state_d;
	ihlt_pkg::opcode_t op_q;

	logic [ihlt_pkg::VEC_W-1:0]      vec_q;
	logic [ihlt_pkg::ID_W-1:0]       id_q;
	logic [ihlt_pkg::CFG_DATA_W-1:0] hw_base_q;
	logic [ihlt_pkg::CFG_DATA_W-1:0] sw_base_q;
	logic [LEN_W-1:0]                n_q, n_d;
	logic [SLOT_W-1:0]               i_q, i_d;
	logic [ihlt_pkg::CLASS_W-1:0]    cls_q, cls_d;
	logic [ihlt_pkg::VEC_W-1:0]      line_q, line_d;
	logic [ihlt_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
	logic                            res_eoi_q, res_eoi_d;

	// Handler slots, one row of MAX_SLOTS entries per vector.
	logic [ihlt_pkg::ID_W-1:0] list_mem [DEPTH];
	logic [ihlt_pkg::ID_W-1:0] list_rd_q;

	// List lengths; an entry whose valid flop is clear reads as zero.
	logic [LEN_W-1:0]       len_mem [NUM_VECTORS];
	logic [NUM_VECTORS-1:0] len_vld_q;
	logic [LEN_W-1:0]       len_rd_q;
	logic                   len_rd_vld_q;

	logic                          out_valid_q;
	logic [ihlt_pkg::STATUS_W-1:0] out_status_q;
	logic [ihlt_pkg::CLASS_W-1:0]  out_class_q;
	logic                          out_hv_q;
	logic [ihlt_pkg::ID_W-1:0]     out_handler_q;
	logic                          out_eoi_q;
	logic [ihlt_pkg::VEC_W-1:0]    out_line_q;
	logic                          out_last_q;

	logic [VIDX_W-1:0]         vidx;
	logic                      in_range;
	logic [LEN_W-1:0]          len_now;
	logic [CNT_W-1:0]          n_ext, i_p1, i_p2;
	logic                      match;
	logic                      disp_fin;
	logic                      out_free;
	logic [ADDR_W-1:0]         base_addr;
	logic                      rd_en, wr_en, len_wr_en;
	logic [SLOT_W-1:0]         rd_slot, wr_slot;
	logic [ihlt_pkg::ID_W-1:0] wr_data;
	logic [LEN_W-1:0]          len_wr_val;
	logic                      emit_hdl, emit_resp;
	logic                      accept;
	logic                      hw_vec;

	assign in_stall  = (state_q != ihlt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	assign vidx      = vec_q[VIDX_W-1:0];
	assign in_range  = ({1'b0, vec_q} < (ihlt_pkg::VEC_W + 1)'(NUM_VECTORS));
	assign len_now   = (len_rd_vld_q && in_range) ? len_rd_q : '0;
	assign n_ext     = CNT_W'(n_q);
	assign i_p1      = CNT_W'(i_q) + CNT_W'(1);
	assign i_p2      = CNT_W'(i_q) + CNT_W'(2);
	assign match     = (list_rd_q == id_q);
	assign disp_fin  = (i_p1 == n_ext);
	assign out_free  = !out_valid_q || !out_stall;
	assign base_addr = ADDR_W'(vidx) * ADDR_W'(MAX_SLOTS);
	assign hw_vec    = (vec_q < sw_base_q);

	always_comb begin
		state_d      = state_q;
		n_d          = n_q;
		i_d          = i_q;
		cls_d        = cls_q;
		line_d       = line_q;
		res_status_d = res_status_q;
		res_eoi_d    = res_eoi_q;
		rd_en        = 1'b0;
		rd_slot      = '0;
		wr_en        = 1'b0;
		wr_slot      = '0;
		wr_data      = id_q;
		len_wr_en    = 1'b0;
		len_wr_val   = '0;
		emit_hdl     = 1'b0;
		emit_resp    = 1'b0;
		case (state_q)
			ihlt_pkg::ST_IDLE: begin
				if (accept && ihlt_pkg::opcode_t'(opcode) != ihlt_pkg::OP_NONE) begin
					state_d = ihlt_pkg::ST_LEN;
				end
			end
			ihlt_pkg::ST_LEN: begin
				n_d          = len_now;
				i_d          = '0;
				cls_d        = ihlt_pkg::CLS_EXC;
				line_d       = '0;
				res_eoi_d    = 1'b0;
				res_status_d = ihlt_pkg::STAT_OK;
				state_d      = ihlt_pkg::ST_RESP;
				case (op_q)
					ihlt_pkg::OP_REG: begin
						if (id_q == '0) begin
							res_status_d = ihlt_pkg::STAT_NULL;
						end else if (!in_range || CNT_W'(len_now) >= CNT_W'(MAX_SLOTS)) begin
							res_status_d = ihlt_pkg::STAT_FULL;
						end else if (len_now == '0) begin
							wr_en      = 1'b1;
							len_wr_en  = 1'b1;
							len_wr_val = LEN_W'(1);
						end else begin
							rd_en   = 1'b1;
							state_d = ihlt_pkg::ST_SCAN;
						end
					end
					ihlt_pkg::OP_UNREG: begin
						if (id_q == '0) begin
							res_status_d = ihlt_pkg::STAT_NULL;
						end else if (!in_range || len_now == '0) begin
							res_status_d = ihlt_pkg::STAT_NOT_FOUND;
						end else begin
							rd_en   = 1'b1;
							state_d = ihlt_pkg::ST_SCAN;
						end
					end
					ihlt_pkg::OP_DISP: begin
						if (vec_q >= hw_base_q) begin
							cls_d     = hw_vec ? ihlt_pkg::CLS_HW : ihlt_pkg::CLS_SW;
							res_eoi_d = hw_vec;
							line_d    = hw_vec ? (vec_q - hw_base_q) : '0;
							if (len_now != '0) begin
								rd_en   = 1'b1;
								state_d = ihlt_pkg::ST_DISP;
							end
						end
					end
					default: begin
						state_d = ihlt_pkg::ST_IDLE;
					end
				endcase
			end
			ihlt_pkg::ST_SCAN: begin
				// The read of the following slot goes out while this one is compared.
				if (i_p1 < n_ext) begin
					rd_en   = 1'b1;
					rd_slot = SLOT_W'(i_p1);
				end
				if (match) begin
					state_d = ihlt_pkg::ST_RESP;
					if (op_q == ihlt_pkg::OP_REG) begin
						res_status_d = ihlt_pkg::STAT_DUP;
					end else if (i_p1 < n_ext) begin
						state_d = ihlt_pkg::ST_SHIFT;
					end else begin
						len_wr_en  = 1'b1;
						len_wr_val = n_q - LEN_W'(1);
					end
				end else if (i_p1 == n_ext) begin
					state_d = ihlt_pkg::ST_RESP;
					if (op_q == ihlt_pkg::OP_REG) begin
						wr_en      = 1'b1;
						wr_slot    = SLOT_W'(n_q);
						len_wr_en  = 1'b1;
						len_wr_val = n_q + LEN_W'(1);
					end else begin
						res_status_d = ihlt_pkg::STAT_NOT_FOUND;
					end
				end else begin
					i_d = i_q + SLOT_W'(1);
				end
			end
			ihlt_pkg::ST_SHIFT: begin
				// Slot i+1 is in the read register; move it down into slot i.
				wr_en   = 1'b1;
				wr_slot = i_q;
				wr_data = list_rd_q;
				if (i_p2 < n_ext) begin
					rd_en   = 1'b1;
					rd_slot = SLOT_W'(i_p2);
					i_d     = i_q + SLOT_W'(1);
				end else begin
					len_wr_en  = 1'b1;
					len_wr_val = n_q - LEN_W'(1);
					state_d    = ihlt_pkg::ST_RESP;
				end
			end
			ihlt_pkg::ST_DISP: begin
				if (out_free) begin
					emit_hdl = 1'b1;
					if (disp_fin) begin
						state_d = ihlt_pkg::ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_slot = SLOT_W'(i_p1);
						i_d     = i_q + SLOT_W'(1);
					end
				end
			end
			ihlt_pkg::ST_RESP: begin
				if (out_free) begin
					emit_resp = 1'b1;
					state_d   = ihlt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ihlt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ihlt_pkg::ST_IDLE;
			hw_base_q <= ihlt_pkg::HW_BASE_RST;
			sw_base_q <= ihlt_pkg::SW_BASE_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					ihlt_pkg::CFG_HW_BASE: hw_base_q <= cfg_data;
					ihlt_pkg::CFG_SW_BASE: sw_base_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ihlt_pkg::opcode_t'(opcode);
			vec_q <= vector;
			id_q  <= handler_id;
		end
		n_q          <= n_d;
		i_q          <= i_d;
		cls_q        <= cls_d;
		line_q       <= line_d;
		res_status_q <= res_status_d;
		res_eoi_q    <= res_eoi_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_mem[base_addr + ADDR_W'(wr_slot)] <= wr_data;
		end
		if (rd_en) begin
			list_rd_q <= list_mem[base_addr + ADDR_W'(rd_slot)];
		end
	end

	always_ff @(posedge clk) begin
		if (len_wr_en) begin
			len_mem[vidx] <= len_wr_val;
		end
		len_rd_q <= len_mem[vector[VIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q    <= '0;
			len_rd_vld_q <= 1'b0;
		end else begin
			if (len_wr_en) begin
				len_vld_q[vidx] <= 1'b1;
			end
			len_rd_vld_q <= len_vld_q[vector[VIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_hdl || emit_resp) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_hdl) begin
			out_status_q  <= ihlt_pkg::STAT_OK;
			out_class_q   <= cls_q;
			out_hv_q      <= 1'b1;
			out_handler_q <= list_rd_q;
			out_eoi_q     <= disp_fin && res_eoi_q;
			out_line_q    <= (disp_fin && res_eoi_q) ? line_q : '0;
			out_last_q    <= disp_fin;
		end else if (emit_resp) begin
			out_status_q  <= res_status_q;
			out_class_q   <= cls_q;
			out_hv_q      <= 1'b0;
			out_handler_q <= '0;
			out_eoi_q     <= res_eoi_q;
			out_line_q    <= res_eoi_q ? line_q : '0;
			out_last_q    <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign vector_class  = out_class_q;
	assign handler_valid = out_hv_q;
	assign handler_out   = out_handler_q;
	assign eoi_valid     = out_eoi_q;
	assign eoi_line      = out_line_q;
	assign last          = out_last_q;

	`IHLT_ASSERT_NEXT(a_item_starts_lookup, accept && opcode != ihlt_pkg::OP_NONE, state_q == ihlt_pkg::ST_LEN, "accepted item did not start a length lookup")
	`IHLT_ASSERT_SAME(a_len_in_bounds, state_q == ihlt_pkg::ST_LEN && len_rd_vld_q, CNT_W'(len_rd_q) <= CNT_W'(MAX_SLOTS), "stored list length exceeds slot count")
	`IHLT_ASSERT_SAME(a_eoi_on_last_hw, out_valid && eoi_valid, last && vector_class == ihlt_pkg::CLS_HW, "end-of-interrupt on a result that is not the last of a hardware dispatch")

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Interrupt handler list table testbench
// Drives register, unregister and dispatch items through several base
// settings and checks every result against a predictor of the handler lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int SETTLE_CYCLES = 16;   // longest item scans a list of up to 8 handlers
	localparam int TAIL_CYCLES   = 20;
	localparam int IDLE_LIMIT    = 2000;
	localparam logic [ihlt_pkg::VEC_W-1:0] HOT_VEC = 8'd40;

	typedef struct packed {
		logic [ihlt_pkg::STATUS_W-1:0] status;
		logic [ihlt_pkg::CLASS_W-1:0]  cls;
		logic                          hv;
		logic [ihlt_pkg::ID_W-1:0]     handler;
		logic                          ev;
		logic [ihlt_pkg::VEC_W-1:0]    line;
		logic                          lst;
	} outcome_t;

	typedef enum logic [1:0] {
		K_ITEM,
		K_CFG,
		K_PAUSE
	} step_kind_t;

	typedef struct {
		step_kind_t                      kind;
		ihlt_pkg::opcode_t               op;
		logic [ihlt_pkg::VEC_W-1:0]      vec;
		logic [ihlt_pkg::ID_W-1:0]       id;
		logic [ihlt_pkg::CFG_IDX_W-1:0]  cfg_idx;
		logic [ihlt_pkg::CFG_DATA_W-1:0] cfg_val;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [1:0]                      opcode = ihlt_pkg::OP_NONE;
	logic [ihlt_pkg::VEC_W-1:0]      vector = '0;
	logic [ihlt_pkg::ID_W-1:0]       handler_id = '0;

	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [ihlt_pkg::STATUS_W-1:0]   status;
	logic [ihlt_pkg::CLASS_W-1:0]    vector_class;
	logic                            handler_valid;
	logic [ihlt_pkg::ID_W-1:0]       handler_out;
	logic                            eoi_valid;
	logic [ihlt_pkg::VEC_W-1:0]      eoi_line;
	logic                            last;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ihlt_pkg::CFG_IDX_W-1:0]  cfg_index = ihlt_pkg::CFG_HW_BASE;
	logic [ihlt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the handler table and the base registers.
	logic [ihlt_pkg::ID_W-1:0]
		slots [ihlt_pkg::NUM_VECTORS_DEF][ihlt_pkg::MAX_SLOTS_DEF];
	int unsigned                     fill [ihlt_pkg::NUM_VECTORS_DEF];
	logic [ihlt_pkg::CFG_DATA_W-1:0] hw_base_cfg = ihlt_pkg::HW_BASE_RST;
	logic [ihlt_pkg::CFG_DATA_W-1:0] sw_base_cfg = ihlt_pkg::SW_BASE_RST;

	outcome_t    due_outcomes[$];
	step_t       pending_steps[$];
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;

	always #5 clk = ~clk;

	interrupt_handler_list_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.vector        (vector),
		.handler_id    (handler_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.vector_class  (vector_class),
		.handler_valid (handler_valid),
		.handler_out   (handler_out),
		.eoi_valid     (eoi_valid),
		.eoi_line      (eoi_line),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic int find_slot(logic [ihlt_pkg::VEC_W-1:0] vec,
			logic [ihlt_pkg::ID_W-1:0] id);
		for (int i = 0; i < fill[vec]; i++)
			if (slots[vec][i] == id)
				return i;
		return -1;
	endfunction

	// Applies one item to the shadow table and queues the results it causes.
	function automatic void handler_table_step(ihlt_pkg::opcode_t op,
			logic [ihlt_pkg::VEC_W-1:0] vec, logic [ihlt_pkg::ID_W-1:0] id);
		outcome_t                     r;
		int                           pos;
		int unsigned                  n;
		logic [ihlt_pkg::CLASS_W-1:0] cls;
		logic                         hw;
		logic [ihlt_pkg::VEC_W-1:0]   line;
		r = '0;
		r.lst = 1'b1;
		case (op)
			ihlt_pkg::OP_REG: begin
				if (id == '0)
					r.status = ihlt_pkg::STAT_NULL;
				else if (fill[vec] >= ihlt_pkg::MAX_SLOTS_DEF)
					r.status = ihlt_pkg::STAT_FULL;
				else if (find_slot(vec, id) >= 0)
					r.status = ihlt_pkg::STAT_DUP;
				else begin
					slots[vec][fill[vec]] = id;
					fill[vec]++;
					r.status = ihlt_pkg::STAT_OK;
				end
				due_outcomes.push_back(r);
			end
			ihlt_pkg::OP_UNREG: begin
				pos = (id == '0) ? -1 : find_slot(vec, id);
				if (id == '0)
					r.status = ihlt_pkg::STAT_NULL;
				else if (pos < 0)
					r.status = ihlt_pkg::STAT_NOT_FOUND;
				else begin
					for (int j = pos; j + 1 < fill[vec]; j++)
						slots[vec][j] = slots[vec][j + 1];
					fill[vec]--;
					r.status = ihlt_pkg::STAT_OK;
				end
				due_outcomes.push_back(r);
			end
			ihlt_pkg::OP_DISP: begin
				if (vec < hw_base_cfg)
					due_outcomes.push_back(r);
				else begin
					cls = (vec < sw_base_cfg) ? ihlt_pkg::CLS_HW : ihlt_pkg::CLS_SW;
					hw = (cls == ihlt_pkg::CLS_HW);
					line = hw ? vec - hw_base_cfg : '0;
					n = fill[vec];
					r.cls = cls;
					if (n == 0) begin
						r.ev = hw;
						r.line = line;
						due_outcomes.push_back(r);
					end else begin
						for (int i = 0; i < n; i++) begin
							r.hv = 1'b1;
							r.handler = slots[vec][i];
							r.lst = (i + 1 == n);
							r.ev = r.lst & hw;
							r.line = r.lst ? line : '0;
							due_outcomes.push_back(r);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [ihlt_pkg::ID_W-1:0] want,
			logic [ihlt_pkg::ID_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void push_item(ihlt_pkg::opcode_t op, logic [ihlt_pkg::VEC_W-1:0] vec,
			logic [ihlt_pkg::ID_W-1:0] id);
		step_t s;
		s.kind = K_ITEM;
		s.op = op;
		s.vec = vec;
		s.id = id;
		s.cfg_idx = '0;
		s.cfg_val = '0;
		pending_steps.push_back(s);
	endfunction

	function automatic void push_ctrl(step_kind_t kind, logic [ihlt_pkg::CFG_IDX_W-1:0] idx,
			logic [ihlt_pkg::CFG_DATA_W-1:0] val);
		step_t s;
		s.kind = kind;
		s.op = ihlt_pkg::OP_NONE;
		s.vec = '0;
		s.id = '0;
		s.cfg_idx = idx;
		s.cfg_val = val;
		pending_steps.push_back(s);
	endfunction

	// Random traffic concentrated on a few vectors and a small pool of IDs, so
	// that lists fill up, duplicates occur and unregisters usually find a match.
	function automatic void random_phase(int unsigned count,
			logic [ihlt_pkg::CFG_DATA_W-1:0] hwb, logic [ihlt_pkg::CFG_DATA_W-1:0] swb);
		logic [ihlt_pkg::ID_W-1:0]  pool [12];
		logic [ihlt_pkg::VEC_W-1:0] focus [4];
		logic [ihlt_pkg::VEC_W-1:0] v;
		logic [ihlt_pkg::ID_W-1:0]  id;
		ihlt_pkg::opcode_t          op;
		int unsigned                made;
		int unsigned                roll;
		for (int i = 0; i < 12; i++)
			pool[i] = (i < 6) ? i + 1 : $urandom;
		focus[0] = HOT_VEC;
		focus[1] = hwb;
		focus[2] = swb - 8'd1;
		focus[3] = swb;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 4)
				v = HOT_VEC;
			else if ($urandom_range(0, 9) < 8)
				v = focus[2'($urandom_range(0, 3))];
			else
				v = 8'($urandom_range(0, 255));
			id = pool[4'($urandom_range(0, 11))];
			if (roll < 45)
				op = ihlt_pkg::OP_REG;
			else if (roll < 70)
				op = ihlt_pkg::OP_UNREG;
			else if (roll < 93)
				op = ihlt_pkg::OP_DISP;
			else if (roll < 96) begin
				op = roll[0] ? ihlt_pkg::OP_REG : ihlt_pkg::OP_UNREG;
				id = '0;
			end else
				op = ihlt_pkg::OP_NONE;
			push_item(op, v, id);
			if (op != ihlt_pkg::OP_NONE)
				made++;
		end
	endfunction

	initial begin
		logic [ihlt_pkg::CFG_DATA_W-1:0] hwb;
		logic [ihlt_pkg::CFG_DATA_W-1:0] swb;
		for (int i = 0; i < ihlt_pkg::NUM_VECTORS_DEF; i++)
			fill[i] = 0;

		// Directed part under the reset bases (32 and 48).
		push_item(ihlt_pkg::OP_DISP, 8'd0, '0);
		push_item(ihlt_pkg::OP_DISP, 8'd255, '0);
		push_item(ihlt_pkg::OP_DISP, 8'd32, '0);
		push_item(ihlt_pkg::OP_DISP, 8'd47, '0);
		push_item(ihlt_pkg::OP_REG, HOT_VEC, '0);
		push_item(ihlt_pkg::OP_UNREG, HOT_VEC, '0);
		push_item(ihlt_pkg::OP_UNREG, HOT_VEC, 32'h0000_0005);
		push_item(ihlt_pkg::OP_REG, HOT_VEC, 32'hFFFF_FFFF);
		push_item(ihlt_pkg::OP_REG, HOT_VEC, 32'h0000_0001);
		push_item(ihlt_pkg::OP_REG, HOT_VEC, 32'hFFFF_FFFF);
		for (int i = 2; i < ihlt_pkg::MAX_SLOTS_DEF; i++)
			push_item(ihlt_pkg::OP_REG, HOT_VEC, 32'h0000_0100 + i);
		push_item(ihlt_pkg::OP_REG, HOT_VEC, 32'h0000_0002);
		push_item(ihlt_pkg::OP_DISP, HOT_VEC, '0);
		push_item(ihlt_pkg::OP_UNREG, HOT_VEC, 32'h0000_0001);
		push_item(ihlt_pkg::OP_UNREG, HOT_VEC, 32'h0000_0001);
		push_item(ihlt_pkg::OP_DISP, HOT_VEC, '0);
		push_item(ihlt_pkg::OP_NONE, HOT_VEC, 32'h0000_0003);
		push_item(ihlt_pkg::OP_REG, 8'd200, 32'h8000_0000);
		push_item(ihlt_pkg::OP_DISP, 8'd200, '0);
		push_ctrl(K_PAUSE, '0, '0);

		// Extremes: no exceptions at all, then crossed and equal bases.
		push_ctrl(K_CFG, ihlt_pkg::CFG_HW_BASE, 8'd0);
		push_ctrl(K_CFG, ihlt_pkg::CFG_SW_BASE, 8'd255);
		random_phase(16, 8'd0, 8'd255);
		push_ctrl(K_CFG, ihlt_pkg::CFG_HW_BASE, 8'd255);
		push_ctrl(K_CFG, ihlt_pkg::CFG_SW_BASE, 8'd0);
		random_phase(16, 8'd255, 8'd0);
		push_ctrl(K_CFG, ihlt_pkg::CFG_HW_BASE, 8'd100);
		push_ctrl(K_CFG, ihlt_pkg::CFG_SW_BASE, 8'd100);
		random_phase(16, 8'd100, 8'd100);

		hwb = 8'($urandom_range(0, 255));
		swb = 8'($urandom_range(0, 255));
		push_ctrl(K_CFG, ihlt_pkg::CFG_HW_BASE, hwb);
		push_ctrl(K_CFG, ihlt_pkg::CFG_SW_BASE, swb);
		random_phase(8, hwb, swb);
		push_ctrl(K_PAUSE, '0, '0);
		random_phase(8, hwb, swb);

		push_ctrl(K_CFG, ihlt_pkg::CFG_HW_BASE, ihlt_pkg::HW_BASE_RST);
		push_ctrl(K_CFG, ihlt_pkg::CFG_SW_BASE, ihlt_pkg::SW_BASE_RST);
		random_phase(16, ihlt_pkg::HW_BASE_RST, ihlt_pkg::SW_BASE_RST);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || in_valid || cfg_valid || due_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Item and register write driver.
	int unsigned gap_left = 0;
	int unsigned settle = 0;
	bit          send_burst = 1'b0;

	always @(posedge clk) begin
		step_t head;
		logic  nxt_valid;
		logic  nxt_cfg;
		nxt_valid = in_valid;
		nxt_cfg = cfg_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				handler_table_step(ihlt_pkg::opcode_t'(opcode), vector, handler_id);
				nxt_valid = 1'b0;
				if ($urandom_range(0, 15) == 0)
					send_burst = !send_burst;
				gap_left = send_burst ? 0 : $urandom_range(0, 9);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ihlt_pkg::CFG_HW_BASE)
					hw_base_cfg = cfg_data;
				else
					sw_base_cfg = cfg_data;
				nxt_cfg = 1'b0;
			end
			if (!nxt_valid && !nxt_cfg && pending_steps.size() != 0) begin
				head = pending_steps[0];
				if (head.kind == K_ITEM) begin
					if (gap_left != 0)
						gap_left--;
					else begin
						opcode <= head.op;
						vector <= head.vec;
						handler_id <= head.id;
						nxt_valid = 1'b1;
						void'(pending_steps.pop_front());
					end
				end else if (due_outcomes.size() != 0)
					settle = 0;
				else if (settle < SETTLE_CYCLES)
					settle++;
				else begin
					// Every result is in and the block has had time to finish
					// any item that produces none.
					settle = 0;
					void'(pending_steps.pop_front());
					if (head.kind == K_CFG) begin
						cfg_index <= head.cfg_idx;
						cfg_data <= head.cfg_val;
						nxt_cfg = 1'b1;
					end
				end
			end
		end
		in_valid <= nxt_valid;
		cfg_valid <= nxt_cfg;
	end

	// Result monitor and stall generator.
	int unsigned stall_left = 0;
	bit          recv_burst = 1'b0;

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_outcomes.size() == 0) begin
					$error("result item arrived with nothing outstanding");
					fail_count++;
				end else begin
					want = due_outcomes.pop_front();
					check_field("status", want.status, status);
					check_field("vector_class", want.cls, vector_class);
					check_field("handler_valid", want.hv, handler_valid);
					check_field("handler_out", want.handler, handler_out);
					check_field("eoi_valid", want.ev, eoi_valid);
					check_field("eoi_line", want.line, eoi_line);
					check_field("last", want.lst, last);
				end
				if ($urandom_range(0, 15) == 0)
					recv_burst = !recv_burst;
				stall_left = recv_burst ? 0 : $urandom_range(0, 9);
			end else if (out_valid && stall_left != 0)
				stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
